// ===== hdl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg: shared definitions for the smoothed peak search unit
// Field widths, register indexes, reset values and the control structs that
// pass between the sequencer, the datapath and the result buffer.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_FRAMES  = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int MAX_ROWS   = 4096;
    localparam int MAX_PLANES = 1024;

    localparam int COL_W      = 8;
    localparam int ROW_W      = 13;
    localparam int PLANE_W    = 11;
    localparam int FRAME_W    = 6;
    localparam int ROW_CNT_W  = 12;
    localparam int PLANE_CNT_W = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES  = 2'd3;

    localparam int RST_COLUMNS = 128;
    localparam int RST_ROWS    = 128;
    localparam int RST_PLANES  = 1;
    localparam int RST_FRAMES  = 1;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
        logic [FRAME_W-1:0] frame;
    } t_pos;

    localparam t_pos POS_RESET = '{col: COL_W'(1), row: ROW_W'(1),
                                   plane: PLANE_W'(1), frame: FRAME_W'(1)};

    // per-beat control from the sequencer to the datapath
    typedef struct packed {
        logic win;
        logic last;
        logic err;
        t_pos pos;
    } t_ctl;

    // result fields other than the sum
    typedef struct packed {
        logic status;
        t_pos pos;
    } t_info;

endpackage

// ===== hdl/sps_seq.sv =====
// ----------------------------------------------------------------------------
// sps_seq: configuration registers and position counters
// Holds the clamped volume sizes, walks frame, column, row and plane counters
// on each accepted beat and derives the store addresses and window flags.
// ----------------------------------------------------------------------------
module sps_seq import sps_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_accept,
    output logic [$clog2(MAX_COLUMNS*MAX_FRAMES)-1:0] o_ls_addr,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] o_fr_addr,
    output t_ctl                          o_ctl
);

    localparam int CXW = $clog2(MAX_COLUMNS);
    localparam int FXW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int AW  = $clog2(MAX_COLUMNS*MAX_FRAMES);
    localparam int CCW = ((CXW > COL_W) ? CXW : COL_W) + 1;
    localparam int FCW = ((FXW > FRAME_W) ? FXW : FRAME_W) + 1;
    localparam int RCW = ROW_W + 1;
    localparam int PCW = PLANE_W + 1;
    localparam int RST_NC = (RST_COLUMNS < MAX_COLUMNS) ? RST_COLUMNS : MAX_COLUMNS;
    localparam int RST_NF = (RST_FRAMES < MAX_FRAMES) ? RST_FRAMES : MAX_FRAMES;

    logic [COL_W-1:0]       r_nc;
    logic [ROW_W-1:0]       r_nr;
    logic [PLANE_W-1:0]     r_np;
    logic [FRAME_W-1:0]     r_nf;
    logic [FXW-1:0]         r_fcnt, n_fcnt;
    logic [CXW-1:0]         r_ccnt, n_ccnt;
    logic [ROW_CNT_W-1:0]   r_rcnt, n_rcnt;
    logic [PLANE_CNT_W-1:0] r_pcnt, n_pcnt;
    logic [FCW-1:0]         f_next;
    logic [CCW-1:0]         c_next;
    logic [RCW-1:0]         r_next;
    logic [PCW-1:0]         p_next;
    logic                   last_f, last_x, last_y, last_p, last_all;

    function automatic logic [COL_W-1:0] clamp_cols(input logic [COL_W-1:0] v);
        logic [COL_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = COL_W'(1);
        end else if (int'(v) > MAX_COLUMNS) begin
            res = COL_W'(MAX_COLUMNS);
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_rows(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = ROW_W'(1);
        end else if (int'(v) > MAX_ROWS) begin
            res = ROW_W'(MAX_ROWS);
        end
        return res;
    endfunction

    function automatic logic [PLANE_W-1:0] clamp_planes(input logic [PLANE_W-1:0] v);
        logic [PLANE_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = PLANE_W'(1);
        end else if (int'(v) > MAX_PLANES) begin
            res = PLANE_W'(MAX_PLANES);
        end
        return res;
    endfunction

    function automatic logic [FRAME_W-1:0] clamp_frames(input logic [FRAME_W-1:0] v);
        logic [FRAME_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = FRAME_W'(1);
        end else if (int'(v) > MAX_FRAMES) begin
            res = FRAME_W'(MAX_FRAMES);
        end
        return res;
    endfunction

    // sizes, clamped at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= COL_W'(RST_NC);
            r_nr <= ROW_W'(RST_ROWS);
            r_np <= PLANE_W'(RST_PLANES);
            r_nf <= FRAME_W'(RST_NF);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_nc <= clamp_cols(i_cfg_data[COL_W-1:0]);
                CFG_ROWS:    r_nr <= clamp_rows(i_cfg_data[ROW_W-1:0]);
                CFG_PLANES:  r_np <= clamp_planes(i_cfg_data[PLANE_W-1:0]);
                CFG_FRAMES:  r_nf <= clamp_frames(i_cfg_data[FRAME_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        f_next   = FCW'(r_fcnt) + FCW'(1);
        c_next   = CCW'(r_ccnt) + CCW'(1);
        r_next   = RCW'(r_rcnt) + RCW'(1);
        p_next   = PCW'(r_pcnt) + PCW'(1);
        last_f   = f_next >= FCW'(r_nf);
        last_x   = c_next >= CCW'(r_nc);
        last_y   = r_next >= RCW'(r_nr);
        last_p   = p_next >= PCW'(r_np);
        last_all = last_f && last_x && last_y && last_p;

        n_fcnt = r_fcnt;
        n_ccnt = r_ccnt;
        n_rcnt = r_rcnt;
        n_pcnt = r_pcnt;
        if (!last_f) begin
            n_fcnt = FXW'(f_next);
        end else begin
            n_fcnt = '0;
            if (!last_x) begin
                n_ccnt = CXW'(c_next);
            end else begin
                n_ccnt = '0;
                if (!last_y) begin
                    n_rcnt = ROW_CNT_W'(r_next);
                end else begin
                    n_rcnt = '0;
                    n_pcnt = last_p ? '0 : PLANE_CNT_W'(p_next);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
            r_ccnt <= '0;
            r_rcnt <= '0;
            r_pcnt <= '0;
        end else if (i_accept) begin
            r_fcnt <= n_fcnt;
            r_ccnt <= n_ccnt;
            r_rcnt <= n_rcnt;
            r_pcnt <= n_pcnt;
        end
    end

    always_comb begin
        o_ls_addr       = AW'(AW'(r_ccnt) * AW'(MAX_FRAMES)) + AW'(r_fcnt);
        o_fr_addr       = r_fcnt;
        o_ctl.win       = (r_rcnt >= ROW_CNT_W'(2)) && (r_ccnt >= CXW'(2));
        o_ctl.last      = last_all;
        o_ctl.err       = (r_nr < ROW_W'(3)) || (r_nc < COL_W'(3));
        o_ctl.pos.col   = COL_W'(r_ccnt);
        o_ctl.pos.row   = ROW_W'(r_rcnt);
        o_ctl.pos.plane = PLANE_W'(r_pcnt) + PLANE_W'(1);
        o_ctl.pos.frame = FRAME_W'(r_fcnt) + FRAME_W'(1);
    end

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && last_all |=>
            (r_fcnt == '0) && (r_ccnt == '0) && (r_rcnt == '0) && (r_pcnt == '0))
        else $error("counters not cleared after final voxel");

endmodule

// ===== hdl/sps_core.sv =====
// ----------------------------------------------------------------------------
// sps_core: line stores, 3x3 weighted sum and peak tracking
// Reads both previous rows and the per-frame column sums at acceptance,
// forms the window sum in the following cycle and keeps the running peak.
// ----------------------------------------------------------------------------
module sps_core import sps_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [$clog2(MAX_COLUMNS*MAX_FRAMES)-1:0] i_ls_addr,
    input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] i_fr_addr,
    input  t_ctl                          i_ctl,
    output logic                          o_res_valid,
    output t_info                         o_res_info,
    output logic signed [SAMPLE_BITS+3:0] o_res_sum
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FXW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int AW   = $clog2(MAX_COLUMNS*MAX_FRAMES);
    localparam int LS_D = MAX_COLUMNS*MAX_FRAMES;
    localparam int CSW  = SB + 2;
    localparam int SW   = SB + 4;
    localparam int BW   = SB + 5;
    localparam int LSW  = 2*SB;
    localparam int FMW  = 2*CSW + SB;
    localparam logic signed [BW-1:0] BEST_RESET = {1'b1, {(BW-1){1'b0}}};

    logic [LSW-1:0] ls_mem [LS_D];
    logic [FMW-1:0] fr_mem [MAX_FRAMES];

    logic                  r_v1;
    t_ctl                  r_ctl1;
    logic signed [SB-1:0]  r_s1;
    logic [AW-1:0]         r_ls_addr1;
    logic [FXW-1:0]        r_fr_addr1;
    logic [LSW-1:0]        r_ls_q, r_ls_fwd_data;
    logic [FMW-1:0]        r_fr_q, r_fr_fwd_data;
    logic                  r_ls_fwd, r_fr_fwd;
    logic signed [BW-1:0]  r_best_sum, n_best_sum;
    t_pos                  r_best_pos, n_best_pos;

    logic [LSW-1:0]        ls_rd, ls_wdata;
    logic [FMW-1:0]        fr_rd, fr_wdata;
    logic signed [SB-1:0]  older, prev, centre;
    logic signed [CSW-1:0] cs, csd_a, csd_b;
    logic signed [SW-1:0]  sum;
    logic                  better;

    always_comb begin
        ls_rd  = r_ls_fwd ? r_ls_fwd_data : r_ls_q;
        fr_rd  = r_fr_fwd ? r_fr_fwd_data : r_fr_q;
        older  = ls_rd[LSW-1:SB];
        prev   = ls_rd[SB-1:0];
        csd_b  = fr_rd[FMW-1:CSW+SB];
        csd_a  = fr_rd[CSW+SB-1:SB];
        centre = fr_rd[SB-1:0];

        cs     = CSW'(older) + CSW'(prev) + CSW'(r_s1);
        sum    = SW'(csd_b) + SW'(csd_a) + SW'(cs) + SW'(centre);
        better = r_ctl1.win && (BW'(sum) > r_best_sum);

        n_best_sum = better ? BW'(sum) : r_best_sum;
        n_best_pos = better ? r_ctl1.pos : r_best_pos;

        ls_wdata = {prev, r_s1};
        fr_wdata = {csd_a, cs, prev};

        o_res_valid       = r_v1 && r_ctl1.last;
        o_res_info.status = r_ctl1.err;
        o_res_info.pos    = r_ctl1.err ? '0 : n_best_pos;
        o_res_sum         = r_ctl1.err ? '0 : SW'(n_best_sum);
    end

    // stores: write from the working stage, read on acceptance
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            ls_mem[r_ls_addr1] <= ls_wdata;
            fr_mem[r_fr_addr1] <= fr_wdata;
        end
        if (i_accept) begin
            r_ls_q        <= ls_mem[i_ls_addr];
            r_fr_q        <= fr_mem[i_fr_addr];
            r_ls_fwd      <= r_v1 && (r_ls_addr1 == i_ls_addr);
            r_fr_fwd      <= r_v1 && (r_fr_addr1 == i_fr_addr);
            r_ls_fwd_data <= ls_wdata;
            r_fr_fwd_data <= fr_wdata;
            r_s1          <= i_sample;
            r_ls_addr1    <= i_ls_addr;
            r_fr_addr1    <= i_fr_addr;
            r_ctl1        <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_best_sum <= BEST_RESET;
            r_best_pos <= POS_RESET;
        end else begin
            r_v1 <= i_accept;
            if (r_v1) begin
                if (r_ctl1.last) begin
                    r_best_sum <= BEST_RESET;
                    r_best_pos <= POS_RESET;
                end else begin
                    r_best_sum <= n_best_sum;
                    r_best_pos <= n_best_pos;
                end
            end
        end
    end

    a_best_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_ctl1.last |=> (r_best_sum == BEST_RESET) && (r_best_pos == POS_RESET))
        else $error("peak not rearmed after result");

endmodule

// ===== hdl/sps_out_buf.sv =====
// ----------------------------------------------------------------------------
// sps_out_buf: two-entry result buffer
// Registers results toward the output channel so the input side keeps
// flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
module sps_out_buf import sps_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  t_info                         i_info,
    input  logic signed [SAMPLE_BITS+3:0] i_sum,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_info                         o_info,
    output logic signed [SAMPLE_BITS+3:0] o_sum,
    output logic [1:0]                    o_level
);

    localparam int SW = SAMPLE_BITS + 4;

    t_info                r_info [2];
    logic signed [SW-1:0] r_sum  [2];
    logic                 r_wptr, r_rptr;
    logic [1:0]           r_count;
    logic                 rd;

    assign rd      = o_valid && i_ready;
    assign o_valid = r_count != 2'd0;
    assign o_info  = r_info[r_rptr];
    assign o_sum   = r_sum[r_rptr];
    assign o_level = r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_info[r_wptr] <= i_info;
            r_sum[r_wptr]  <= i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (rd) begin
                r_rptr <= ~r_rptr;
            end
            if (i_wr && !rd) begin
                r_count <= r_count + 2'd1;
            end else if (!i_wr && rd) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr && !rd |-> (r_count != 2'd2))
        else $error("result buffer overflow");

    a_fill_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr && (r_count == 2'd0) |=> o_valid && (o_sum == $past(i_sum)))
        else $error("written result not presented");

endmodule

// ===== hdl/smoothed_peak_search_unit.sv =====
// ----------------------------------------------------------------------------
// smoothed_peak_search_unit: streamed 3x3 smoothing peak search
// Finds the first greatest centre-weighted 3x3 in-plane sum over a volume
// and reports it with its 1-based column, row, plane and frame.
// ----------------------------------------------------------------------------
// The unit takes one voxel beat per clock cycle, in plane, row, column, frame
// order, with no dead cycles between volumes and no clearing pass after
// reset. Each beat reads both previous rows from a line store of
// MAX_COLUMNS*MAX_FRAMES words of 2*SAMPLE_BITS bits in the cycle it is
// accepted and writes them back in the following cycle; that single read and
// write port per cycle sets the rate of one beat per cycle. The result of a
// volume is registered in the result buffer before it is presented. Two
// results can wait unread; input ready drops only while that buffer would
// otherwise overflow. The reported sum is ten times the smoothed value.
module smoothed_peak_search_unit import sps_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_result_valid,
    input  logic                          i_result_ready,
    output logic                          o_status,
    output logic signed [SAMPLE_BITS+3:0] o_peak_sum,
    output logic [COL_W-1:0]              o_peak_column,
    output logic [ROW_W-1:0]              o_peak_row,
    output logic [PLANE_W-1:0]            o_peak_plane,
    output logic [FRAME_W-1:0]            o_peak_frame
);

    localparam int FXW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int AW  = $clog2(MAX_COLUMNS*MAX_FRAMES);

    logic                          accept;
    logic [AW-1:0]                 ls_addr;
    logic [FXW-1:0]                fr_addr;
    t_ctl                          ctl;
    logic                          res_valid;
    t_info                         res_info, out_info;
    logic signed [SAMPLE_BITS+3:0] res_sum;
    logic [1:0]                    level;

    assign accept = i_sample_valid && o_sample_ready;

    // results in flight: buffered plus one in the working stage
    assign o_sample_ready = !(((level == 2'd2) || ((level == 2'd1) && res_valid)) &&
                              !i_result_ready);

    sps_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_FRAMES  (MAX_FRAMES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_ls_addr   (ls_addr),
        .o_fr_addr   (fr_addr),
        .o_ctl       (ctl)
    );

    sps_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .i_ls_addr   (ls_addr),
        .i_fr_addr   (fr_addr),
        .i_ctl       (ctl),
        .o_res_valid (res_valid),
        .o_res_info  (res_info),
        .o_res_sum   (res_sum)
    );

    sps_out_buf #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (res_valid),
        .i_info   (res_info),
        .i_sum    (res_sum),
        .o_valid  (o_result_valid),
        .i_ready  (i_result_ready),
        .o_info   (out_info),
        .o_sum    (o_peak_sum),
        .o_level  (level)
    );

    assign o_status      = out_info.status;
    assign o_peak_column = out_info.pos.col;
    assign o_peak_row    = out_info.pos.row;
    assign o_peak_plane  = out_info.pos.plane;
    assign o_peak_frame  = out_info.pos.frame;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_status |->
            (o_peak_sum == '0) && (o_peak_column == '0) && (o_peak_row == '0) &&
            (o_peak_plane == '0) && (o_peak_frame == '0))
        else $error("error result carries nonzero fields");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_ready |-> o_result_valid)
        else $error("input stalled with no result waiting");

endmodule
